// ----- design/srt_pkg.sv -----
// shared constants, types and helpers of the reverb tank
package srt_pkg;

   localparam int MAX_DELAY     = 4096;
   localparam int NUM_COMBS     = 4;
   localparam int NUM_ALLPASSES = 2;

   localparam int SAMPLE_W      = 24;
   localparam int GAIN_W        = 16;
   localparam int DELAY_FIELD_W = 12;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 3;

   // delay lines are addressed modulo MAX_DELAY, a power of two
   localparam int ADDR_W      = $clog2(MAX_DELAY);
   localparam int FILL_W      = ADDR_W + 1;
   localparam int COMB_IDX_W  = $clog2(NUM_COMBS);
   localparam int AP_IDX_W    = $clog2(NUM_ALLPASSES);
   localparam int COMB_DEPTH  = NUM_COMBS * MAX_DELAY;
   localparam int AP_DEPTH    = NUM_ALLPASSES * MAX_DELAY;
   localparam int COMB_ADDR_W = $clog2(COMB_DEPTH);
   localparam int AP_ADDR_W   = $clog2(AP_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_COMB_FEEDBACK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMP_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLPASS_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMB_DELAYS_A  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMB_DELAYS_B  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLPASS_DELAYS = 3'd5;

   localparam logic [GAIN_W-1:0]     RST_COMB_FEEDBACK  = 16'd55050;
   localparam logic [GAIN_W-1:0]     RST_DAMP_GAIN      = 16'd13107;
   localparam logic [GAIN_W-1:0]     RST_ALLPASS_GAIN   = 16'd32768;
   localparam logic [CSR_DATA_W-1:0] RST_COMB_DELAYS_A  = 24'd4867164;
   localparam logic [CSR_DATA_W-1:0] RST_COMB_DELAYS_B  = 24'd5555453;
   localparam logic [CSR_DATA_W-1:0] RST_ALLPASS_DELAYS = 24'd1806892;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_COMB_P1,
      OP_COMB_P2,
      OP_COMB_DAMP,
      OP_COMB_P3,
      OP_COMB_WR,
      OP_AP_P,
      OP_AP_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type               op;
      logic [COMB_IDX_W-1:0]   comb_sel;
      logic                    first_ap;
      logic                    line_valid;
   } dp_ctrl_type;

   // zero reads as one, anything above capacity as capacity
   function automatic logic [ADDR_W:0] line_delay(input logic [DELAY_FIELD_W-1:0] field);
      int unsigned d;
      d = (field == '0) ? 1 : 32'(field);
      if (d > MAX_DELAY) d = MAX_DELAY;
      return (ADDR_W + 1)'(d);
   endfunction

endpackage

// ----- design/srt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module srt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/srt_dpath.sv -----
// shared multiplier datapath: comb damping, feedback and allpass arithmetic
module srt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  srt_pkg::dp_ctrl_type                 ctrl,
   input  logic signed [srt_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [srt_pkg::SAMPLE_W-1:0]         comb_rd_data,
   input  logic [srt_pkg::SAMPLE_W-1:0]         ap_rd_data,
   input  logic [srt_pkg::GAIN_W-1:0]           comb_feedback,
   input  logic [srt_pkg::GAIN_W-1:0]           damp_gain,
   input  logic [srt_pkg::GAIN_W-1:0]           allpass_gain,
   output logic [srt_pkg::SAMPLE_W-1:0]         comb_wr_data,
   output logic [srt_pkg::SAMPLE_W-1:0]         ap_wr_data,
   output logic signed [srt_pkg::SAMPLE_W-1:0]  sample_out
);
   import srt_pkg::*;

   localparam int MUL_B_W = GAIN_W + 2;
   localparam int PROD_W  = SAMPLE_W + MUL_B_W;
   localparam int SUM_W   = SAMPLE_W + COMB_IDX_W;
   localparam int WIDE_W  = SAMPLE_W + 3;
   localparam int RND_W   = PROD_W - GAIN_W;
   localparam logic signed [PROD_W:0] ROUND = (PROD_W + 1)'(1) <<< (GAIN_W - 1);
   localparam logic signed [WIDE_W-1:0] SMAX = WIDE_W'((1 <<< (SAMPLE_W - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] SMIN = -WIDE_W'(1 <<< (SAMPLE_W - 1));

   logic signed [SAMPLE_W-1:0] damp_ff [NUM_COMBS];
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   acc_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] buf_ff;
   logic signed [SAMPLE_W-1:0] v_ff;

   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [SAMPLE_W-1:0] ap_buf;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic [GAIN_W:0]            damp_inv;
   logic signed [PROD_W:0]     damp_acc;
   logic signed [SAMPLE_W-1:0] damp_next;
   logic signed [PROD_W:0]     prod_rnd;
   logic signed [RND_W-1:0]    gain_term;

   function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
      if (v > SMAX) return SMAX[SAMPLE_W-1:0];
      if (v < SMIN) return SMIN[SAMPLE_W-1:0];
      return v[SAMPLE_W-1:0];
   endfunction

   // unwritten line entries read as zero
   assign delayed  = ctrl.line_valid ? signed'(comb_rd_data) : '0;
   assign ap_buf   = ctrl.line_valid ? signed'(ap_rd_data) : '0;
   assign damp_inv = (GAIN_W + 1)'(1 << GAIN_W) - {1'b0, damp_gain};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         OP_COMB_P1: begin
            mul_a = delayed;
            mul_b = signed'({2'b00, damp_gain});
         end
         OP_COMB_P2: begin
            mul_a = damp_ff[ctrl.comb_sel];
            mul_b = signed'({1'b0, damp_inv});
         end
         OP_COMB_P3: begin
            mul_a = damp_ff[ctrl.comb_sel];
            mul_b = signed'({2'b00, comb_feedback});
         end
         OP_AP_P: begin
            mul_a = ap_buf;
            mul_b = signed'({2'b00, allpass_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // one-pole damping result lies between its two inputs
   assign damp_acc  = (PROD_W + 1)'(acc_ff) + (PROD_W + 1)'(prod_ff) + ROUND;
   assign damp_next = damp_acc[GAIN_W +: SAMPLE_W];

   assign prod_rnd  = (PROD_W + 1)'(prod_ff) + ROUND;
   assign gain_term = prod_rnd[GAIN_W +: RND_W];

   assign comb_wr_data = sat_sample(WIDE_W'(x_ff) + WIDE_W'(gain_term));
   assign ap_wr_data   = sat_sample(WIDE_W'(v_ff) + WIDE_W'(gain_term));
   assign sample_out   = v_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a * mul_b);
      unique case (ctrl.op)
         OP_LOAD: begin
            x_ff   <= sample_in;
            sum_ff <= '0;
         end
         OP_COMB_P1: sum_ff <= sum_ff + SUM_W'(delayed);
         OP_COMB_P2: acc_ff <= prod_ff;
         OP_AP_P: begin
            buf_ff <= ap_buf;
            if (ctrl.first_ap) v_ff <= sum_ff[SUM_W-1:COMB_IDX_W];
         end
         OP_AP_WR: v_ff <= signed'(sat_sample(WIDE_W'(buf_ff) - WIDE_W'(v_ff)));
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COMBS; k++) damp_ff[k] <= '0;
      end else if (ctrl.op == OP_COMB_DAMP) begin
         damp_ff[ctrl.comb_sel] <= damp_next;
      end
   end

endmodule

// ----- design/schroeder_reverb_tank.sv -----
// reverb tank top level: sequencer, registers, delay line memories
// one transaction at a time: a new input is taken only once the last result has left S_DONE
// the pace is set by the single shared multiplier (three products per comb, one per
//    allpass) and the memory read of each line
// reset: synchronous; lines read as zero until written, tracked by a fill count,
//    so there is no clearing pass and the block takes input right after reset
module schroeder_reverb_tank (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [srt_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [srt_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                 csr_wr_en,
   input  logic [srt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [srt_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import srt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_C_RD,
      S_C_MUL1,
      S_C_MUL2,
      S_C_DAMP,
      S_C_MUL3,
      S_C_WR,
      S_A_MUL,
      S_A_WR,
      S_DONE
   } state_type;

   localparam logic [COMB_IDX_W-1:0] LAST_COMB = COMB_IDX_W'(NUM_COMBS - 1);
   localparam logic [AP_IDX_W-1:0]   LAST_AP   = AP_IDX_W'(NUM_ALLPASSES - 1);

   state_type                  state_ff;
   logic [COMB_IDX_W-1:0]      comb_sel_ff;
   logic [AP_IDX_W-1:0]        ap_sel_ff;
   logic                       line_valid_ff;
   logic [ADDR_W-1:0]          wp_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic [GAIN_W-1:0]     comb_feedback_ff;
   logic [GAIN_W-1:0]     damp_gain_ff;
   logic [GAIN_W-1:0]     allpass_gain_ff;
   logic [CSR_DATA_W-1:0] comb_delays_a_ff;
   logic [CSR_DATA_W-1:0] comb_delays_b_ff;
   logic [CSR_DATA_W-1:0] allpass_delays_ff;

   logic [ADDR_W:0]         comb_delay [NUM_COMBS];
   logic [ADDR_W:0]         ap_delay [NUM_ALLPASSES];
   logic [COMB_IDX_W-1:0]   comb_rd_sel;
   logic [AP_IDX_W-1:0]     ap_rd_sel;
   logic                    comb_rd_en;
   logic                    ap_rd_en;
   logic [COMB_ADDR_W-1:0]  comb_rd_addr;
   logic [AP_ADDR_W-1:0]    ap_rd_addr;
   logic                    comb_wr_en;
   logic                    ap_wr_en;
   logic [COMB_ADDR_W-1:0]  comb_wr_addr;
   logic [AP_ADDR_W-1:0]    ap_wr_addr;
   logic [SAMPLE_W-1:0]     comb_wr_data;
   logic [SAMPLE_W-1:0]     ap_wr_data;
   logic [SAMPLE_W-1:0]     comb_rd_data;
   logic [SAMPLE_W-1:0]     ap_rd_data;
   logic                    line_valid_in;
   logic                    out_free;
   logic signed [SAMPLE_W-1:0] dp_sample;
   dp_ctrl_type             dp_ctrl;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         comb_feedback_ff  <= RST_COMB_FEEDBACK;
         damp_gain_ff      <= RST_DAMP_GAIN;
         allpass_gain_ff   <= RST_ALLPASS_GAIN;
         comb_delays_a_ff  <= RST_COMB_DELAYS_A;
         comb_delays_b_ff  <= RST_COMB_DELAYS_B;
         allpass_delays_ff <= RST_ALLPASS_DELAYS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COMB_FEEDBACK:  comb_feedback_ff  <= csr_wr_data[GAIN_W-1:0];
            CSR_DAMP_GAIN:      damp_gain_ff      <= csr_wr_data[GAIN_W-1:0];
            CSR_ALLPASS_GAIN:   allpass_gain_ff   <= csr_wr_data[GAIN_W-1:0];
            CSR_COMB_DELAYS_A:  comb_delays_a_ff  <= csr_wr_data;
            CSR_COMB_DELAYS_B:  comb_delays_b_ff  <= csr_wr_data;
            CSR_ALLPASS_DELAYS: allpass_delays_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      comb_delay[0] = line_delay(comb_delays_a_ff[DELAY_FIELD_W-1:0]);
      comb_delay[1] = line_delay(comb_delays_a_ff[2*DELAY_FIELD_W-1:DELAY_FIELD_W]);
      comb_delay[2] = line_delay(comb_delays_b_ff[DELAY_FIELD_W-1:0]);
      comb_delay[3] = line_delay(comb_delays_b_ff[2*DELAY_FIELD_W-1:DELAY_FIELD_W]);
      ap_delay[0]   = line_delay(allpass_delays_ff[DELAY_FIELD_W-1:0]);
      ap_delay[1]   = line_delay(allpass_delays_ff[2*DELAY_FIELD_W-1:DELAY_FIELD_W]);
   end

   // read issue: next line is read while the current one writes back
   always_comb begin
      comb_rd_sel = (state_ff == S_C_WR) ? COMB_IDX_W'(comb_sel_ff + 1'b1) : '0;
      ap_rd_sel   = (state_ff == S_A_WR) ? AP_IDX_W'(ap_sel_ff + 1'b1) : '0;
      comb_rd_en  = (state_ff == S_C_RD) ||
                    (state_ff == S_C_WR && comb_sel_ff != LAST_COMB);
      ap_rd_en    = (state_ff == S_C_WR && comb_sel_ff == LAST_COMB) ||
                    (state_ff == S_A_WR && ap_sel_ff != LAST_AP);
      comb_rd_addr = {comb_rd_sel, wp_ff - comb_delay[comb_rd_sel][ADDR_W-1:0]};
      ap_rd_addr   = {ap_rd_sel, wp_ff - ap_delay[ap_rd_sel][ADDR_W-1:0]};
      line_valid_in = comb_rd_en ? (fill_ff >= comb_delay[comb_rd_sel])
                                 : (fill_ff >= ap_delay[ap_rd_sel]);
   end

   assign comb_wr_en   = (state_ff == S_C_WR);
   assign ap_wr_en     = (state_ff == S_A_WR);
   assign comb_wr_addr = {comb_sel_ff, wp_ff};
   assign ap_wr_addr   = {ap_sel_ff, wp_ff};
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == S_IDLE);

   always_comb begin
      dp_ctrl.comb_sel   = comb_sel_ff;
      dp_ctrl.first_ap   = (ap_sel_ff == '0);
      dp_ctrl.line_valid = line_valid_ff;
      unique case (state_ff)
         S_IDLE:   dp_ctrl.op = req_valid ? OP_LOAD : OP_IDLE;
         S_C_MUL1: dp_ctrl.op = OP_COMB_P1;
         S_C_MUL2: dp_ctrl.op = OP_COMB_P2;
         S_C_DAMP: dp_ctrl.op = OP_COMB_DAMP;
         S_C_MUL3: dp_ctrl.op = OP_COMB_P3;
         S_C_WR:   dp_ctrl.op = OP_COMB_WR;
         S_A_MUL:  dp_ctrl.op = OP_AP_P;
         S_A_WR:   dp_ctrl.op = OP_AP_WR;
         default:  dp_ctrl.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         comb_sel_ff   <= '0;
         ap_sel_ff     <= '0;
         line_valid_ff <= 1'b0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (comb_rd_en || ap_rd_en) line_valid_ff <= line_valid_in;
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  comb_sel_ff <= '0;
                  state_ff    <= S_C_RD;
               end
            end
            S_C_RD:   state_ff <= S_C_MUL1;
            S_C_MUL1: state_ff <= S_C_MUL2;
            S_C_MUL2: state_ff <= S_C_DAMP;
            S_C_DAMP: state_ff <= S_C_MUL3;
            S_C_MUL3: state_ff <= S_C_WR;
            S_C_WR: begin
               if (comb_sel_ff == LAST_COMB) begin
                  ap_sel_ff <= '0;
                  state_ff  <= S_A_MUL;
               end else begin
                  comb_sel_ff <= comb_rd_sel;
                  state_ff    <= S_C_MUL1;
               end
            end
            S_A_MUL: state_ff <= S_A_WR;
            S_A_WR: begin
               if (ap_sel_ff == LAST_AP) begin
                  state_ff <= S_DONE;
               end else begin
                  ap_sel_ff <= ap_rd_sel;
                  state_ff  <= S_A_MUL;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_sample_ff <= dp_sample;
                  wp_ff         <= ADDR_W'(wp_ff + 1'b1);
                  if (fill_ff != FILL_W'(MAX_DELAY)) fill_ff <= FILL_W'(fill_ff + 1'b1);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   srt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (COMB_DEPTH)
   ) u_comb_ram (
      .clock   (clock),
      .wr_en   (comb_wr_en),
      .wr_addr (comb_wr_addr),
      .wr_data (comb_wr_data),
      .rd_en   (comb_rd_en),
      .rd_addr (comb_rd_addr),
      .rd_data (comb_rd_data)
   );

   srt_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (AP_DEPTH)
   ) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_wr_en),
      .wr_addr (ap_wr_addr),
      .wr_data (ap_wr_data),
      .rd_en   (ap_rd_en),
      .rd_addr (ap_rd_addr),
      .rd_data (ap_rd_data)
   );

   srt_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (dp_ctrl),
      .sample_in     (req_sample_in),
      .comb_rd_data  (comb_rd_data),
      .ap_rd_data    (ap_rd_data),
      .comb_feedback (comb_feedback_ff),
      .damp_gain     (damp_gain_ff),
      .allpass_gain  (allpass_gain_ff),
      .comb_wr_data  (comb_wr_data),
      .ap_wr_data    (ap_wr_data),
      .sample_out    (dp_sample)
   );

   // a write never lands on the entry read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      comb_wr_en && comb_rd_en |-> comb_wr_addr != comb_rd_addr)
      else $error("comb write and read collide");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_DELAY))
      else $error("fill count beyond capacity");

   // a new result only appears after the last allpass has written back
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result without completed transaction");

   // the write pointer moves only when a transaction completes
   assert property (@(posedge clock) disable iff (reset)
      !$stable(wp_ff) |-> $past(state_ff == S_DONE) && $past(out_free))
      else $error("write pointer moved mid transaction");

endmodule
